>>> hw/rtl/vgmcse_pkg.sv
// Shared types and constants for the VGM command stream encoder.
// Depends on nothing; every other file of the block imports it.
package vgmcse_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_DELAY = 2'd1;
  localparam logic [1:0] REQ_LOOP  = 2'd2;
  localparam logic [1:0] REQ_STOP  = 2'd3;

  // Command bytes of the stream.
  localparam logic [7:0] CMD_C352       = 8'hE1;
  localparam logic [7:0] CMD_PSG        = 8'h50;
  localparam logic [7:0] CMD_PSG_ALT    = 8'h30;
  localparam logic [7:0] CMD_YM_END     = 8'h60;
  localparam logic [7:0] CMD_WAIT       = 8'h61;
  localparam logic [7:0] CMD_WAIT_SHORT = 8'h70;
  localparam logic [7:0] CMD_END        = 8'h66;
  localparam logic [7:0] BYTE_FF        = 8'hFF;

  // Delay accumulator: hundredths of a sample, saturating.
  localparam int unsigned ACC_W   = 27;
  localparam logic [ACC_W-1:0] ACC_CAP = 27'd117963099;
  // Reciprocal of 100: floor(acc * DIV_MULT / 2^DIV_SHIFT) == acc / 100 for acc <= ACC_CAP.
  localparam logic [ACC_W-1:0] DIV_MULT  = 27'd85899346;
  localparam int unsigned      DIV_SHIFT = 33;
  localparam int unsigned      PROD_W    = 2 * ACC_W;
  localparam int unsigned      N_W       = PROD_W - DIV_SHIFT;   // whole samples, 21 bits
  localparam logic [16:0]      FULL_WAIT = 17'd65535;
  localparam logic [15:0]      SHORT_MAX = 16'd16;

  localparam int unsigned FULL_W   = 5;    // at most 18 full waits
  localparam int unsigned TAIL_MAX = 5;    // longest register write layout
  localparam int unsigned TAIL_W   = $clog2(TAIL_MAX);
  localparam int unsigned BYTES_W  = 6;    // at most 59 bytes per job

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  chip_command;
    logic [7:0]  chip_port;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic [23:0] delay_amount;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] total_samples;
    logic [31:0] loop_samples;
    logic        loop_valid;
    logic [31:0] loop_offset;
    logic [31:0] stream_length;
  } out_item_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_SHORT,
    WAIT_LONG
  } wait_kind_t;

  // One queued job: the wait sequence, the command bytes and the totals.
  typedef struct packed {
    logic [FULL_W-1:0]            full_cnt;
    logic [15:0]                  rest;
    wait_kind_t                   wait_kind;
    logic [TAIL_MAX-1:0][7:0]     tail;
    logic [BYTES_W-1:0]           byte_cnt;
    logic [31:0]                  total_samples;
    logic [31:0]                  loop_samples;
    logic                         loop_valid;
    logic [31:0]                  loop_offset;
    logic [31:0]                  stream_length;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_SPLIT,
    F_ISSUE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FULL,
    B_REST,
    B_TAIL
  } back_phase_t;

endpackage

>>> hw/rtl/vgm_command_stream_encoder.sv
// VGM command stream encoder, top level: front end, job queue and byte back end.
// Depends on vgmcse_pkg, vgmcse_front, vgmcse_queue and vgmcse_back.
//
// This block turns a stream of requests (sound-chip register writes, delays in
// hundredths of a sample, a loop mark and a stop) into the bytes of a VGM command
// stream, one byte per output transaction, with the last flag on the final byte
// that a request causes. A delay request only adds to the saturating delay
// accumulator. Any other request occupies the front end through acceptance, a
// multiplication by the reciprocal of 100, the split of the pending wait into
// full 65535-sample waits and a rest, and the issue of a job into the queue,
// where the front end holds if the queue is full. The back end then sends the
// job's bytes, one per cycle while out_stall is low, after loading the job in
// its idle phase; a C352 write that flushes the longest wait yields 59 bytes,
// the most that any request yields. A stop request emits the end marker 0x66
// with the sample total, the loop length, the loop byte offset and the stream
// length on all of its bytes, and then returns the stream state to its reset
// values. The output is registered, so the next byte is prepared while the
// current one waits under out_stall.
module vgm_command_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2   // jobs held between front and back, 2 or more
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  vgmcse_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output vgmcse_pkg::out_item_t out_item
);
  import vgmcse_pkg::*;

  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t push_job;
  job_t pop_job;

  // Front end: request handling, delay arithmetic and stream bookkeeping.
  vgmcse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .job      (push_job),
    .q_full   (q_full)
  );

  // Queue so that the front end can work on the next request while bytes drain.
  vgmcse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (pop_job)
  );

  // Back end: byte sequencer and output register.
  vgmcse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> hw/rtl/vgmcse_front.sv
// Front end of the VGM encoder: accepts requests, keeps the delay and stream state,
// and turns each request into a job for the queue. Depends on vgmcse_pkg.
module vgmcse_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vgmcse_pkg::in_item_t in_item,
  output logic                 push,
  output vgmcse_pkg::job_t     job,
  input  logic                 q_full
);
  import vgmcse_pkg::*;

  front_state_t state_r, state_nxt;
  in_item_t     item_r;

  logic [ACC_W-1:0]  acc_r;
  logic [31:0]       samples_r;
  logic [31:0]       loop_smp_r;
  logic [31:0]       loop_pos_r;
  logic [31:0]       pos_r;

  logic [PROD_W-1:0] prod_r;
  logic [N_W-1:0]    n_r;
  logic [FULL_W-1:0] full_r;
  logic [15:0]       rest_r;
  logic [6:0]        frac_r;

  logic              accept;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_sat;

  logic [N_W-1:0]    q_div;
  logic [ACC_W-1:0]  q_times;
  logic [6:0]        frac;
  logic [FULL_W-1:0] hi_part;
  logic [16:0]       split_sum;
  logic              split_ge;
  logic [FULL_W-1:0] full_cnt;
  logic [15:0]       rest;

  logic              flush;
  wait_kind_t        wkind;
  logic [FULL_W-1:0] full_use;
  logic [BYTES_W-1:0] wait_bytes;
  logic [BYTES_W-1:0] total_bytes;
  logic [TAIL_MAX-1:0][7:0] tail;
  logic [BYTES_W-1:0] tail_len;
  logic [31:0]       smp_new;
  logic [31:0]       pos_flush;
  logic              issue_done;

  function automatic logic [23:0] item_sel_delay(input in_item_t it);
    return it.delay_amount;
  endfunction

  assign accept = in_valid && !in_stall;

  // Saturating add of a delay request.
  assign acc_sum = {1'b0, acc_r} + (ACC_W + 1)'(item_sel_delay(in_item));
  assign acc_sat = (acc_sum > {1'b0, ACC_CAP}) ? ACC_CAP : acc_sum[ACC_W-1:0];

  // Quotient by 100, its remainder, and the split into full waits and the rest.
  assign q_div     = prod_r[PROD_W-1:DIV_SHIFT];
  assign q_times   = ACC_W'(q_div) * ACC_W'(100);
  assign frac      = 7'(acc_r - q_times);
  assign hi_part   = q_div[N_W-1:16];
  assign split_sum = 17'(hi_part) + {1'b0, q_div[15:0]};
  assign split_ge  = split_sum >= FULL_WAIT;
  assign full_cnt  = hi_part + FULL_W'(split_ge);
  assign rest      = split_ge ? 16'(split_sum - FULL_WAIT) : split_sum[15:0];

  // Job assembly in the issue state.
  always_comb begin
    flush    = n_r > N_W'(1);
    full_use = flush ? full_r : '0;
    if (!flush) begin
      wkind = WAIT_NONE;
    end else if (rest_r > SHORT_MAX) begin
      wkind = WAIT_LONG;
    end else if (rest_r != 16'd0) begin
      wkind = WAIT_SHORT;
    end else begin
      wkind = WAIT_NONE;
    end
    wait_bytes = BYTES_W'({1'b0, full_use}) * BYTES_W'(3);
    if (wkind == WAIT_LONG) begin
      wait_bytes = wait_bytes + BYTES_W'(3);
    end else if (wkind == WAIT_SHORT) begin
      wait_bytes = wait_bytes + BYTES_W'(1);
    end

    tail     = '0;
    tail_len = '0;
    if (item_r.req_type == REQ_WRITE) begin
      if (item_r.chip_command == CMD_C352) begin
        tail[0]  = item_r.chip_command;
        tail[1]  = item_r.reg_address[15:8];
        tail[2]  = item_r.reg_address[7:0];
        tail[3]  = item_r.reg_value[15:8];
        tail[4]  = item_r.reg_value[7:0];
        tail_len = BYTES_W'(5);
      end else if (item_r.chip_command > CMD_PSG && item_r.chip_command < CMD_YM_END) begin
        tail[0]  = item_r.chip_command + item_r.chip_port;
        tail[1]  = item_r.reg_address[7:0];
        tail[2]  = item_r.reg_value[7:0];
        tail_len = BYTES_W'(3);
      end else if (item_r.chip_command == CMD_PSG || item_r.chip_command == CMD_PSG_ALT) begin
        tail[0]  = item_r.chip_command;
        tail[1]  = item_r.reg_value[7:0];
        tail_len = BYTES_W'(2);
      end else begin
        tail[0]  = item_r.chip_command;
        tail[1]  = item_r.chip_port;
        tail[2]  = item_r.reg_address[7:0];
        tail[3]  = item_r.reg_value[7:0];
        tail_len = BYTES_W'(4);
      end
    end else if (item_r.req_type == REQ_STOP) begin
      tail[0]  = CMD_END;
      tail_len = BYTES_W'(1);
    end

    total_bytes = wait_bytes + tail_len;
    smp_new     = samples_r + (flush ? 32'(n_r) : 32'd0);
    pos_flush   = pos_r + 32'(wait_bytes);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && in_item.req_type != REQ_DELAY) begin
          state_nxt = F_DIV;
        end
      end
      F_DIV:   state_nxt = F_SPLIT;
      F_SPLIT: state_nxt = F_ISSUE;
      F_ISSUE: begin
        if (issue_done) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall   = (state_r != F_IDLE);
    issue_done = (state_r == F_ISSUE) && ((total_bytes == '0) || !q_full);
    push       = (state_r == F_ISSUE) && (total_bytes != '0) && !q_full;

    job.full_cnt      = full_use;
    job.rest          = rest_r;
    job.wait_kind     = wkind;
    job.tail          = tail;
    job.byte_cnt      = total_bytes;
    job.total_samples = smp_new;
    if (item_r.req_type == REQ_STOP) begin
      job.loop_valid    = (loop_smp_r != 32'd0);
      job.loop_samples  = (loop_smp_r != 32'd0) ? (smp_new - loop_smp_r) : 32'd0;
      job.loop_offset   = loop_pos_r;
      job.stream_length = pos_flush + 32'd1;
    end else begin
      job.loop_valid    = 1'b0;
      job.loop_samples  = '0;
      job.loop_offset   = '0;
      job.stream_length = '0;
    end
  end

  // Control and stream state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      acc_r      <= '0;
      samples_r  <= '0;
      loop_smp_r <= '0;
      loop_pos_r <= '0;
      pos_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_IDLE && accept && in_item.req_type == REQ_DELAY) begin
        acc_r <= acc_sat;
      end
      if (issue_done) begin
        if (item_r.req_type == REQ_STOP) begin
          acc_r      <= '0;
          samples_r  <= '0;
          loop_smp_r <= '0;
          loop_pos_r <= '0;
          pos_r      <= '0;
        end else begin
          if (flush) begin
            acc_r     <= ACC_W'(frac_r);
            samples_r <= smp_new;
          end
          if (item_r.req_type == REQ_LOOP) begin
            loop_smp_r <= smp_new;
            loop_pos_r <= pos_flush;
          end
          pos_r <= pos_r + 32'(total_bytes);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (state_r == F_DIV) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(DIV_MULT);
    end
    if (state_r == F_SPLIT) begin
      n_r    <= q_div;
      full_r <= full_cnt;
      rest_r <= rest;
      frac_r <= frac;
    end
  end

endmodule

>>> hw/rtl/vgmcse_queue.sv
// Short job queue between the front and back ends of the VGM encoder.
// Depends on vgmcse_pkg for the job type.
module vgmcse_queue #(
  parameter int unsigned DEPTH = 2   // 2 or more
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vgmcse_pkg::job_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output vgmcse_pkg::job_t pop_data
);
  import vgmcse_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/vgmcse_back.sv
// Back end of the VGM encoder: takes one job from the queue and sends its bytes
// through a registered output stage. Depends on vgmcse_pkg.
module vgmcse_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  vgmcse_pkg::job_t      q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output vgmcse_pkg::out_item_t out_item
);
  import vgmcse_pkg::*;

  back_phase_t        phase_r, phase_nxt;
  logic [TAIL_W-1:0]  sub_r, sub_nxt;
  logic [FULL_W-1:0]  full_left_r, full_left_nxt;
  logic [BYTES_W-1:0] left_r;
  job_t               job_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               advance;
  logic [7:0]         byte_cur;

  assign advance   = (phase_r != B_IDLE) && (!out_valid_r || !out_stall);
  assign q_pop     = (phase_r == B_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Next phase, byte index and full-wait count.
  always_comb begin
    phase_nxt     = phase_r;
    sub_nxt       = sub_r;
    full_left_nxt = full_left_r;
    unique case (phase_r)
      B_IDLE: begin
        sub_nxt       = '0;
        full_left_nxt = q_data.full_cnt;
        if (q_valid) begin
          if (q_data.full_cnt != '0) begin
            phase_nxt = B_FULL;
          end else if (q_data.wait_kind != WAIT_NONE) begin
            phase_nxt = B_REST;
          end else begin
            phase_nxt = B_TAIL;
          end
        end
      end
      B_FULL: begin
        if (sub_r == TAIL_W'(2)) begin
          sub_nxt       = '0;
          full_left_nxt = full_left_r - FULL_W'(1);
          if (full_left_r == FULL_W'(1)) begin
            phase_nxt = (job_r.wait_kind != WAIT_NONE) ? B_REST : B_TAIL;
          end
        end else begin
          sub_nxt = sub_r + TAIL_W'(1);
        end
      end
      B_REST: begin
        if (job_r.wait_kind == WAIT_SHORT || sub_r == TAIL_W'(2)) begin
          sub_nxt   = '0;
          phase_nxt = B_TAIL;
        end else begin
          sub_nxt = sub_r + TAIL_W'(1);
        end
      end
      B_TAIL:  sub_nxt = sub_r + TAIL_W'(1);
      default: phase_nxt = B_IDLE;
    endcase
    if (phase_r != B_IDLE && left_r == BYTES_W'(1)) begin
      phase_nxt = B_IDLE;
    end
  end

  // Byte for the current position.
  always_comb begin
    unique case (phase_r)
      B_FULL: byte_cur = (sub_r == '0) ? CMD_WAIT : BYTE_FF;
      B_REST: begin
        if (job_r.wait_kind == WAIT_SHORT) begin
          byte_cur = CMD_WAIT_SHORT + job_r.rest[7:0] - 8'd1;
        end else if (sub_r == '0) begin
          byte_cur = CMD_WAIT;
        end else if (sub_r == TAIL_W'(1)) begin
          byte_cur = job_r.rest[7:0];
        end else begin
          byte_cur = job_r.rest[15:8];
        end
      end
      B_TAIL:  byte_cur = job_r.tail[sub_r];
      default: byte_cur = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= B_IDLE;
      sub_r       <= '0;
      full_left_r <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        sub_r       <= sub_nxt;
        full_left_r <= full_left_nxt;
        left_r      <= q_data.byte_cnt;
      end else if (advance) begin
        phase_r     <= phase_nxt;
        sub_r       <= sub_nxt;
        full_left_r <= full_left_nxt;
        left_r      <= left_r - BYTES_W'(1);
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if (advance) begin
      out_r.out_byte      <= byte_cur;
      out_r.last          <= (left_r == BYTES_W'(1));
      out_r.total_samples <= job_r.total_samples;
      out_r.loop_samples  <= job_r.loop_samples;
      out_r.loop_valid    <= job_r.loop_valid;
      out_r.loop_offset   <= job_r.loop_offset;
      out_r.stream_length <= job_r.stream_length;
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the VGM command stream encoder.
// Depends on vgmcse_pkg and vgm_command_stream_encoder; needs nothing else.
module tb_top;
  import vgmcse_pkg::*;

  // One hundred fractional units make one whole sample.
  localparam int unsigned FRAC_PER_SAMPLE = 100;
  // The receiver's long hold-off starts once this many requests have gone in.
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 200;
  // Random requests wanted after the directed part.
  localparam int RANDOM_ITEMS = 117;
  // Once this few requests remain, neither side idles any more.
  localparam int QUIET_TAIL   = 25;
  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int STUCK_LIMIT  = 3000;
  // Cycles to watch for stray bytes once every expected byte has arrived.
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    in_item_t item;
    bit       drain;  // hold this request back until the output has caught up
  } request_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  vgm_command_stream_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Requests waiting to be offered, and the bytes the stream should carry next.
  request_t  request_queue[$];
  out_item_t expected_bytes[$];

  int n_requests = 0;
  int n_taken = 0;
  int n_errors = 0;

  // Our own copy of the stream state, mirroring what the block must keep.
  int unsigned acc_hundredths = 0;
  logic [31:0] samples_done = '0;
  logic [31:0] loop_mark_samples = '0;
  logic [31:0] loop_mark_bytes = '0;
  logic [31:0] bytes_emitted = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Works out the bytes that one accepted request produces and queues them.
  // A delay only feeds the saturating accumulator. Anything else first flushes
  // a pending wait of two or more whole samples, leaving the fraction behind;
  // a lone whole sample is deliberately left where it is.
  task automatic encode_request(input in_item_t req);
    logic [7:0]  burst[$];
    int unsigned whole;
    int unsigned full_waits;
    int unsigned rest;
    int unsigned sum;
    logic [31:0] lsamp;
    logic [31:0] loff;
    logic [31:0] slen;
    logic        lvalid;
    bit          stop;
    out_item_t   res;
    lsamp  = '0;
    loff   = '0;
    slen   = '0;
    lvalid = 1'b0;
    stop   = 1'b0;
    if (req.req_type == REQ_DELAY) begin
      sum = acc_hundredths + req.delay_amount;
      acc_hundredths = (sum > ACC_CAP) ? ACC_CAP : sum;
    end else begin
      whole = acc_hundredths / FRAC_PER_SAMPLE;
      if (whole > 1) begin
        acc_hundredths = acc_hundredths % FRAC_PER_SAMPLE;
        samples_done   = samples_done + whole;
        full_waits     = whole / FULL_WAIT;
        rest           = whole % FULL_WAIT;
        repeat (full_waits) begin
          burst.push_back(CMD_WAIT);
          burst.push_back(BYTE_FF);
          burst.push_back(BYTE_FF);
        end
        if (rest > SHORT_MAX) begin
          burst.push_back(CMD_WAIT);
          burst.push_back(8'(rest));
          burst.push_back(8'(rest >> 8));
        end else if (rest > 0) begin
          burst.push_back(8'(CMD_WAIT_SHORT + rest - 1));
        end
      end
      case (req.req_type)
        REQ_WRITE: begin
          if (req.chip_command == CMD_C352) begin
            burst.push_back(req.chip_command);
            burst.push_back(req.reg_address[15:8]);
            burst.push_back(req.reg_address[7:0]);
            burst.push_back(req.reg_value[15:8]);
            burst.push_back(req.reg_value[7:0]);
          end else if (req.chip_command > CMD_PSG && req.chip_command < CMD_YM_END) begin
            burst.push_back(8'(req.chip_command + req.chip_port));
            burst.push_back(req.reg_address[7:0]);
            burst.push_back(req.reg_value[7:0]);
          end else if (req.chip_command == CMD_PSG || req.chip_command == CMD_PSG_ALT) begin
            burst.push_back(req.chip_command);
            burst.push_back(req.reg_value[7:0]);
          end else begin
            burst.push_back(req.chip_command);
            burst.push_back(req.chip_port);
            burst.push_back(req.reg_address[7:0]);
            burst.push_back(req.reg_value[7:0]);
          end
        end
        REQ_LOOP: begin
          // The mark lands after any wait flushed by this very request.
          loop_mark_samples = samples_done;
          loop_mark_bytes   = bytes_emitted + burst.size();
        end
        default: begin
          burst.push_back(CMD_END);
          stop   = 1'b1;
          lvalid = (loop_mark_samples != 0);
          lsamp  = lvalid ? samples_done - loop_mark_samples : '0;
          loff   = loop_mark_bytes;
          slen   = bytes_emitted + burst.size();
        end
      endcase
      bytes_emitted = bytes_emitted + burst.size();
      foreach (burst[i]) begin
        res.out_byte      = burst[i];
        res.last          = (i == burst.size() - 1);
        res.total_samples = samples_done;
        res.loop_samples  = lsamp;
        res.loop_valid    = lvalid;
        res.loop_offset   = loff;
        res.stream_length = slen;
        expected_bytes.push_back(res);
      end
      // A stop closes the stream and everything starts again from zero.
      if (stop) begin
        acc_hundredths    = 0;
        samples_done      = '0;
        loop_mark_samples = '0;
        loop_mark_bytes   = '0;
        bytes_emitted     = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Idling is allowed only away from the tail of the run, and it is switched off
  // in every fourth window of sixteen requests so that some stretches run flat out.
  function automatic bit idling_allowed();
    return request_queue.size() > QUIET_TAIL && ((n_taken / 16) % 4 != 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction. Fields that a request does not use are filled at
  // random so that nothing leaks from them into the stream.
  // ---------------------------------------------------------------------------
  function automatic in_item_t random_fields(input logic [1:0] req);
    in_item_t it;
    it.req_type     = req;
    it.chip_command = 8'($urandom);
    it.chip_port    = 8'($urandom);
    it.reg_address  = 16'($urandom);
    it.reg_value    = 16'($urandom);
    it.delay_amount = 24'($urandom);
    return it;
  endfunction

  task automatic add_request(input in_item_t it, input bit drain);
    request_t r;
    r.item  = it;
    r.drain = drain;
    request_queue.push_back(r);
    n_requests++;
  endtask

  task automatic add_write(input logic [7:0] cmd, input logic [7:0] port,
                           input logic [15:0] addr, input logic [15:0] value,
                           input bit drain);
    in_item_t it;
    it = random_fields(REQ_WRITE);
    it.chip_command = cmd;
    it.chip_port    = port;
    it.reg_address  = addr;
    it.reg_value    = value;
    add_request(it, drain);
  endtask

  task automatic queue_pause(input logic [23:0] amount);
    in_item_t it;
    it = random_fields(REQ_DELAY);
    it.delay_amount = amount;
    add_request(it, 1'b0);
  endtask

  // One stream of random content closed by a stop. Most streams are well formed
  // writes and delays with the odd loop mark; a few carry an early stop.
  task automatic add_random_stream(input bit drain);
    int          len;
    int          pick;
    logic [7:0]  cmd;
    logic [23:0] amount;
    len = $urandom_range(2, 14);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 5))
          0:       cmd = CMD_C352;
          1:       cmd = 8'($urandom_range(CMD_PSG + 1, CMD_YM_END - 1));
          2:       cmd = CMD_PSG;
          3:       cmd = CMD_PSG_ALT;
          default: cmd = 8'($urandom);
        endcase
        add_write(cmd, 8'($urandom), 16'($urandom), 16'($urandom), drain && k == 0);
      end else if (pick < 82) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: amount = 24'($urandom_range(0, 2000));
          12, 13, 14, 15, 16:                   amount = 24'($urandom_range(0, 700000));
          17, 18:                               amount = 24'($urandom_range(0, 8000000));
          default:                              amount = 24'($urandom);
        endcase
        queue_pause(amount);
      end else if (pick < 90) begin
        add_request(random_fields(REQ_LOOP), drain && k == 0);
      end else if (pick < 93) begin
        add_request(random_fields(REQ_STOP), drain && k == 0);
      end else begin
        add_request(random_fields(2'($urandom)), drain && k == 0);
      end
    end
    add_request(random_fields(REQ_STOP), 1'b0);
  endtask

  int n_streams;

  initial begin
    // Directed part: a loop mark at sample zero with nothing to flush, every
    // write layout at the edges of its fields, then each kind of wait.
    add_request(random_fields(REQ_LOOP), 1'b0);
    add_write(CMD_C352, 8'h12, 16'hFFFF, 16'hFFFF, 1'b0);
    add_write(CMD_PSG + 1, 8'h00, 16'h0000, 16'hFFFF, 1'b0);
    add_write(CMD_YM_END - 1, 8'hFF, 16'hFFFF, 16'h0000, 1'b0);
    add_write(CMD_PSG, 8'hFF, 16'hFFFF, 16'hA5FF, 1'b0);
    add_write(CMD_PSG_ALT, 8'h00, 16'h0000, 16'h5A00, 1'b0);
    add_write(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    add_write(CMD_YM_END, 8'h01, 16'h1234, 16'h5678, 1'b0);
    add_write(8'h4F, 8'h80, 16'h8001, 16'h0180, 1'b0);
    queue_pause(24'd0);
    // A single whole sample is never flushed by a write.
    queue_pause(24'd100);
    add_write(CMD_C352, 8'h00, 16'h0000, 16'h0000, 1'b0);
    // Sixteen samples give the longest short wait, flushed by a loop mark.
    queue_pause(24'd1500);
    add_request(random_fields(REQ_LOOP), 1'b0);
    // Seventeen samples need the three-byte wait.
    queue_pause(24'd1700);
    add_write(8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
    // Exactly one full wait, then a third loop mark that replaces the second.
    queue_pause(24'd6553500);
    add_request(random_fields(REQ_LOOP), 1'b0);
    // Saturate the accumulator: eighteen full waits ahead of a C352 write.
    repeat (8) queue_pause(24'hFFFFFF);
    add_write(CMD_C352, 8'h55, 16'hC3A5, 16'h5AC3, 1'b0);
    queue_pause(24'd250);
    add_request(random_fields(REQ_STOP), 1'b0);
    // A fresh stream with its loop mark at sample zero but a non-zero byte
    // offset, and a lone pending sample that the stop simply drops.
    add_write(8'h90, 8'h01, 16'h0002, 16'h0003, 1'b1);
    add_request(random_fields(REQ_LOOP), 1'b0);
    queue_pause(24'd199);
    add_request(random_fields(REQ_STOP), 1'b0);

    // Random part; every fourth stream waits for the output to drain first.
    n_streams = 0;
    while (n_requests < 33 + RANDOM_ITEMS) begin
      add_random_stream(n_streams % 4 == 1);
      n_streams++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken != n_requests || expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      report_mismatch("bytes still missing at the end", expected_bytes.size(), 0);
    end
    if (n_errors == 0) begin
      $display("vgm_command_stream_encoder: match");
    end else begin
      $display("vgm_command_stream_encoder: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver. A transaction completes at an edge where in_valid is high and
  // in_stall low; only then may the payload move on. Random idle bursts are
  // slotted in between transactions, and a request flagged to drain is held
  // back until every byte expected so far has been seen.
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_request(in_item);
        n_taken <= n_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_queue.size() == 0 ||
                     (request_queue[0].drain && expected_bytes.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b1;
          in_item  <= request_queue[0].item;
          void'(request_queue.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure. Short random stalls, plus one long hold-off while
  // the sender keeps offering, so that the block's job queue fills and it has
  // to stall its own input.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_taken >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every output transaction is checked, field by field, against the
  // oldest byte still expected.
  // ---------------------------------------------------------------------------
  out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with nothing expected", out_item.out_byte, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_item.out_byte, want.out_byte);
        if (out_item.last !== want.last)
          report_mismatch("last", out_item.last, want.last);
        if (out_item.total_samples !== want.total_samples)
          report_mismatch("total_samples", out_item.total_samples, want.total_samples);
        if (out_item.loop_samples !== want.loop_samples)
          report_mismatch("loop_samples", out_item.loop_samples, want.loop_samples);
        if (out_item.loop_valid !== want.loop_valid)
          report_mismatch("loop_valid", out_item.loop_valid, want.loop_valid);
        if (out_item.loop_offset !== want.loop_offset)
          report_mismatch("loop_offset", out_item.loop_offset, want.loop_offset);
        if (out_item.stream_length !== want.stream_length)
          report_mismatch("stream_length", out_item.stream_length, want.stream_length);
      end
    end
  end

  // Watchdog: gives up once neither channel has moved a transaction for too long.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("vgm_command_stream_encoder: mismatch");
        $finish;
      end
    end
  end

endmodule

>>> files.f
hw/rtl/vgmcse_pkg.sv
hw/rtl/vgmcse_front.sv
hw/rtl/vgmcse_queue.sv
hw/rtl/vgmcse_back.sv
hw/rtl/vgm_command_stream_encoder.sv
dv/tb_top.sv
